[rtl/npic_pkg.sv]
`timescale 1ns / 1ps

package npic_pkg;

  localparam int LEVELS   = 8;
  localparam int LVL_W    = 3;   // width of an in-range level
  localparam int REQ_LVL_W = 4;  // width of the requested level field

  typedef enum logic {
    CMD_RAISE = 1'b0,
    CMD_END   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                 command;
    logic [REQ_LVL_W-1:0] level;
  } npic_req_t;

  typedef struct packed {
    logic             dispatch_valid;
    logic [LVL_W-1:0] dispatch_level;
    logic [LVL_W-1:0] current_level;
    logic             error_flag;
  } npic_rsp_t;

  // Highest set bit of pend strictly above floor; zero when there is none.
  function automatic logic [LVL_W-1:0] highest_above(logic [LEVELS-1:0] pend,
                                                     logic [LVL_W-1:0]  floor);
    logic [LVL_W-1:0] found;
    found = '0;
    for (int j = 0; j < LEVELS; j++) begin
      if (pend[j] && (LVL_W'(j) > floor)) begin
        found = LVL_W'(j);
      end
    end
    return found;
  endfunction

endpackage

[rtl/npic_core.sv]
`timescale 1ns / 1ps

module npic_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  npic_pkg::npic_req_t req,
  output npic_pkg::npic_rsp_t rsp
);

  logic [npic_pkg::LEVELS-1:0] pending;
  logic [npic_pkg::LEVELS-1:0] pending_next;
  logic [npic_pkg::LVL_W-1:0]  saved [npic_pkg::LEVELS];
  logic [npic_pkg::LVL_W-1:0]  cur;
  logic [npic_pkg::LVL_W-1:0]  cur_next;

  logic [npic_pkg::LEVELS-1:0] pend_mid;
  logic [npic_pkg::LVL_W-1:0]  base;
  logic [npic_pkg::LVL_W-1:0]  found;
  logic                        err;
  logic                        start;

  always_comb begin
    err      = 1'b0;
    pend_mid = pending;
    base     = cur;
    if (req.command == npic_pkg::CMD_RAISE) begin
      if (req.level >= npic_pkg::REQ_LVL_W'(npic_pkg::LEVELS)) begin
        err = 1'b1;
      end else begin
        pend_mid[req.level[npic_pkg::LVL_W-1:0]] = 1'b1;
      end
    end else begin
      if (cur == '0) begin
        err = 1'b1;
      end else begin
        base = saved[cur];   // pop the interrupted priority
      end
    end

    found        = npic_pkg::highest_above(pend_mid, base);
    start        = !err && (found != '0);
    pending_next = pend_mid;
    cur_next     = base;
    if (start) begin
      pending_next[found] = 1'b0;
      cur_next            = found;
    end
    if (err) begin
      pending_next = pending;
      cur_next     = cur;
    end

    rsp.dispatch_valid = start;
    rsp.dispatch_level = start ? found : '0;
    rsp.current_level  = cur_next;
    rsp.error_flag     = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      cur     <= '0;
    end else if (en) begin
      pending <= pending_next;
      cur     <= cur_next;
    end
  end

  // saved priorities are written on dispatch only; no reset needed
  always_ff @(posedge clk) begin
    if (en && start) begin
      saved[found] <= base;
    end
  end

endmodule

[rtl/nested_priority_interrupt_controller.sv]
`timescale 1ns / 1ps
// A request accepted into the input register reaches m_tvalid through the result register.
// Throughput: one request per cycle; s_tready drops only while both the input
//   register and the result register hold data and m_tready is low.
// One priority encode over the pending bits plus the state update per request.
// Reset (rst, synchronous, active high) clears pending bits, the current
//   priority and both valid flags; saved priorities are left as they are.

module nested_priority_interrupt_controller (
  input  logic       clk,
  input  logic       rst,
  // request stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [0] command, [4:1] level, [7:5] zero
  // result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] dispatch_valid, [3:1] dispatch_level,
                                // [6:4] current_level, [7] error_flag
);

  // Input register stage
  logic                in_valid;
  npic_pkg::npic_req_t in_req;

  // Result register stage
  logic                out_valid;
  npic_pkg::npic_rsp_t out_rsp;

  npic_pkg::npic_rsp_t rsp;
  logic                advance;   // result register can take a new value
  logic                fire;      // request in the input register is processed
  logic                s_fire;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_fire || (in_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_req.command <= npic_pkg::cmd_t'(s_tdata[0]);
      in_req.level   <= s_tdata[npic_pkg::REQ_LVL_W:1];
    end
  end

  // State and the dispatch decision live in the core; it updates on fire only.
  npic_core u_core (
    .clk (clk),
    .rst (rst),
    .en  (fire),
    .req (in_req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rsp <= rsp;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_rsp.error_flag, out_rsp.current_level,
                     out_rsp.dispatch_level, out_rsp.dispatch_valid};

  // A dispatched level becomes the current level and is never an error.
  a_dispatch_is_current: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[3:1] == m_tdata[6:4]) && !m_tdata[7])
    else $error("dispatched level differs from current level");

  // Without a dispatch, dispatch_level reports zero.
  a_idle_level_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[3:1] == 3'd0))
    else $error("dispatch_level nonzero without dispatch");

  // A processed request always lands in the result register next cycle.
  a_fire_lands: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed request lost");

  // The core never reports a dispatch together with an error.
  a_no_err_dispatch: assert property (@(posedge clk) disable iff (rst)
    fire |-> !(rsp.error_flag && rsp.dispatch_valid))
    else $error("dispatch on an erroneous request");

endmodule
